[src/sha1_pkg.sv]
// SHA-1 hasher package: round constants, initial chaining words and the
// command/status bundles between the controller and the datapath.
// No dependencies.
package sha1_pkg;

  localparam int WordW  = 32;
  localparam int CountW = 61;
  localparam int RoundW = 7;
  localparam int PosW   = 6;
  localparam int IdxW   = 3;

  localparam logic [RoundW-1:0] LastRound = 7'd79;
  localparam logic [PosW-1:0]   LastPos   = 6'd63;
  localparam logic [PosW-1:0]   LenPos    = 6'd56;
  localparam logic [IdxW-1:0]   LastWord  = 3'd4;
  localparam logic [7:0]        PadByte   = 8'h80;

  localparam logic [WordW-1:0] Init0 = 32'h67452301;
  localparam logic [WordW-1:0] Init1 = 32'hEFCDAB89;
  localparam logic [WordW-1:0] Init2 = 32'h98BADCFE;
  localparam logic [WordW-1:0] Init3 = 32'h10325476;
  localparam logic [WordW-1:0] Init4 = 32'hC3D2E1F0;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic load_byte;
    logic pad_start;
    logic pad_step;
    logic round_step;
    logic chain_add;
    logic arm;
    logic out_shift;
    logic reload;
  } sha1_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pad_last;
    logic round_last;
    logic armed;
    logic word_last;
  } sha1_sts_t;

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] rnd);
    logic [WordW-1:0] k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RoundW-1:0] rnd,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

[src/sha1_datapath.sv]
// SHA-1 datapath: 512-bit block shift register doubling as the message
// schedule window, working and chaining words, byte count and padding state.
// Depends on sha1_pkg.
module sha1_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  sha1_pkg::sha1_cmd_t         cmd,
  input  logic [7:0]                  data_byte,
  output sha1_pkg::sha1_sts_t         sts,
  output logic [sha1_pkg::WordW-1:0]  digest_word,
  output logic [sha1_pkg::IdxW-1:0]   word_index
);

  logic [511:0]                  blk;
  logic [sha1_pkg::WordW-1:0]    a, b, c, d, e;
  logic [sha1_pkg::WordW-1:0]    h0, h1, h2, h3, h4;
  logic [sha1_pkg::CountW-1:0]   count;
  logic [sha1_pkg::RoundW-1:0]   rnd;
  logic [sha1_pkg::PosW-1:0]     pad_pos;
  logic                          pad_first;
  logic                          armed;
  logic [63:0]                   len_sr;
  logic [sha1_pkg::IdxW-1:0]     idx;

  logic [7:0]                    pad_byte;
  logic                          len_phase;
  logic [sha1_pkg::WordW-1:0]    w0, w2, w8, w13, w_new, t_sum;

  assign w0  = blk[511:480];
  assign w2  = blk[447:416];
  assign w8  = blk[255:224];
  assign w13 = blk[95:64];

  always_comb begin
    w_new = {w13 ^ w8 ^ w2 ^ w0};
    w_new = {w_new[30:0], w_new[31]};
  end

  assign t_sum = {a[26:0], a[31:27]} + sha1_pkg::round_f(rnd, b, c, d) + e
                 + sha1_pkg::round_k(rnd) + w0;

  assign len_phase = armed && (pad_pos >= sha1_pkg::LenPos);

  always_comb begin
    if (pad_first) begin
      pad_byte = sha1_pkg::PadByte;
    end else if (len_phase) begin
      pad_byte = len_sr[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // block buffer: bytes enter at the bottom, words leave at the top
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      blk <= {blk[503:0], data_byte};
    end else if (cmd.pad_step) begin
      blk <= {blk[503:0], pad_byte};
    end else if (cmd.round_step) begin
      blk <= {blk[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pad_start) begin
      len_sr <= {count, 3'b000};
    end else if (cmd.pad_step && !pad_first && len_phase) begin
      len_sr <= {len_sr[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a       <= sha1_pkg::Init0;
      b       <= sha1_pkg::Init1;
      c       <= sha1_pkg::Init2;
      d       <= sha1_pkg::Init3;
      e       <= sha1_pkg::Init4;
      h0      <= sha1_pkg::Init0;
      h1      <= sha1_pkg::Init1;
      h2      <= sha1_pkg::Init2;
      h3      <= sha1_pkg::Init3;
      h4      <= sha1_pkg::Init4;
      count   <= '0;
      rnd     <= '0;
      pad_pos <= '0;
      pad_first <= 1'b0;
      armed   <= 1'b0;
      idx     <= '0;
    end else begin
      if (cmd.load_byte) begin
        count <= count + 1'b1;
      end
      if (cmd.round_step) begin
        a   <= t_sum;
        b   <= a;
        c   <= {b[1:0], b[31:2]};
        d   <= c;
        e   <= d;
        rnd <= (rnd == sha1_pkg::LastRound) ? '0 : rnd + 1'b1;
      end
      // fold the working words into the chain and restart from it
      if (cmd.chain_add) begin
        h0 <= h0 + a;
        h1 <= h1 + b;
        h2 <= h2 + c;
        h3 <= h3 + d;
        h4 <= h4 + e;
        a  <= h0 + a;
        b  <= h1 + b;
        c  <= h2 + c;
        d  <= h3 + d;
        e  <= h4 + e;
      end
      if (cmd.pad_start) begin
        pad_pos   <= count[sha1_pkg::PosW-1:0];
        pad_first <= 1'b1;
        armed     <= (count[sha1_pkg::PosW-1:0] < sha1_pkg::LenPos);
      end else if (cmd.pad_step) begin
        pad_pos   <= pad_pos + 1'b1;
        pad_first <= 1'b0;
      end
      if (cmd.arm) begin
        armed <= 1'b1;
      end
      if (cmd.reload) begin
        a     <= sha1_pkg::Init0;
        b     <= sha1_pkg::Init1;
        c     <= sha1_pkg::Init2;
        d     <= sha1_pkg::Init3;
        e     <= sha1_pkg::Init4;
        h0    <= sha1_pkg::Init0;
        h1    <= sha1_pkg::Init1;
        h2    <= sha1_pkg::Init2;
        h3    <= sha1_pkg::Init3;
        h4    <= sha1_pkg::Init4;
        count <= '0;
        idx   <= '0;
      end else if (cmd.out_shift) begin
        // rotate the chain so the next digest word sits in h0
        h0  <= h1;
        h1  <= h2;
        h2  <= h3;
        h3  <= h4;
        h4  <= h0;
        idx <= idx + 1'b1;
      end
    end
  end

  assign sts.pos_last   = (count[sha1_pkg::PosW-1:0] == sha1_pkg::LastPos);
  assign sts.pad_last   = (pad_pos == sha1_pkg::LastPos);
  assign sts.round_last = (rnd == sha1_pkg::LastRound);
  assign sts.armed      = armed;
  assign sts.word_last  = (idx == sha1_pkg::LastWord);

  assign digest_word = h0;
  assign word_index  = idx;

endmodule

[src/sha1_ctrl.sv]
// SHA-1 controller: sequences byte loading, padding, the 80 rounds, the
// chain update and the digest words. Depends on sha1_pkg.
module sha1_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 byte_valid,
  input  logic                 in_last,
  input  logic                 out_ready,
  input  sha1_pkg::sha1_sts_t  sts,
  output logic                 in_ready,
  output logic                 out_valid,
  output sha1_pkg::sha1_cmd_t  cmd
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StComp   = 3'd1;
  localparam logic [2:0] StFin    = 3'd2;
  localparam logic [2:0] StPadIni = 3'd3;
  localparam logic [2:0] StPad    = 3'd4;
  localparam logic [2:0] StOut    = 3'd5;

  logic [2:0] state, state_next;
  logic       pend_last, pend_last_next;
  logic       in_pad, in_pad_next;
  logic       acc;

  assign in_ready  = (state == StIdle);
  assign out_valid = (state == StOut);
  assign acc       = in_ready && in_valid;

  always_comb begin
    state_next     = state;
    pend_last_next = pend_last;
    in_pad_next    = in_pad;
    cmd            = '0;
    case (state)
      StIdle: begin
        if (acc) begin
          if (byte_valid) begin
            cmd.load_byte = 1'b1;
            if (sts.pos_last) begin
              pend_last_next = in_last;
              state_next     = StComp;
            end else if (in_last) begin
              state_next = StPadIni;
            end
          end else if (in_last) begin
            state_next = StPadIni;
          end
        end
      end
      StComp: begin
        cmd.round_step = 1'b1;
        if (sts.round_last) begin
          state_next = StFin;
        end
      end
      StFin: begin
        cmd.chain_add = 1'b1;
        if (in_pad) begin
          if (sts.armed) begin
            state_next = StOut;
          end else begin
            // length goes in the next block
            cmd.arm    = 1'b1;
            state_next = StPad;
          end
        end else if (pend_last) begin
          pend_last_next = 1'b0;
          state_next     = StPadIni;
        end else begin
          state_next = StIdle;
        end
      end
      StPadIni: begin
        cmd.pad_start = 1'b1;
        in_pad_next   = 1'b1;
        state_next    = StPad;
      end
      StPad: begin
        cmd.pad_step = 1'b1;
        if (sts.pad_last) begin
          state_next = StComp;
        end
      end
      StOut: begin
        if (out_ready) begin
          cmd.out_shift = 1'b1;
          if (sts.word_last) begin
            cmd.reload  = 1'b1;
            in_pad_next = 1'b0;
            state_next  = StIdle;
          end
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      pend_last <= 1'b0;
      in_pad    <= 1'b0;
    end else begin
      state     <= state_next;
      pend_last <= pend_last_next;
      in_pad    <= in_pad_next;
    end
  end

endmodule

[src/sha1_message_hasher_unit.sv]
// SHA-1 message hasher top level: joins the controller and the datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_datapath.
//
//   channel | direction | tdata         | tuser          | tlast
//   s_*     | in        | data_byte[7:0]| byte_valid     | last
//   m_*     | out       | digest_word   | word_index     | digest_end
//
// One byte per cycle while the block buffer fills; the 64th byte of a block
// starts a compression: 80 rounds of the single round unit, then the chain
// update. An end item takes a padding setup, then pads byte by byte and runs
// one or two padding compressions before the five digest words.
// Synchronous reset loads the initial chain and clears the byte count.
// Input is held off while a compression, padding or digest output runs;
// a stalled digest word holds until taken.
module sha1_message_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] byte_valid
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast
);

  sha1_pkg::sha1_cmd_t cmd;
  sha1_pkg::sha1_sts_t sts;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .byte_valid (s_tuser[0]),
    .in_last    (s_tlast),
    .out_ready  (m_tready),
    .sts        (sts),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .cmd        (cmd)
  );

  sha1_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_tdata),
    .sts         (sts),
    .digest_word (m_tdata),
    .word_index  (m_tuser)
  );

  assign m_tlast = (m_tuser == sha1_pkg::LastWord);

endmodule

[src/sha1_checker.sv]
// Port-level checks for the SHA-1 hasher, attached by bind.
// Depends on sha1_message_hasher_unit.
module sha1_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled digest transfer holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("digest word changed while stalled");

  // no input is taken while a digest is being delivered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready during digest output");

  // words advance in order, one index per transfer
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
    else $error("digest word index out of sequence");

  // the final word ends the digest and frees the input
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
    else $error("output continued after final digest word");

endmodule

bind sha1_message_hasher_unit sha1_checker u_sha1_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
